@@ rtl/primitive_assembler_defines.svh @@
// ---------------------------------------------------------------------------
// primitive_assembler_defines
// Assertion macros used by the primitive assembler RTL.
// ---------------------------------------------------------------------------
`ifndef PRIMITIVE_ASSEMBLER_DEFINES_SVH
`define PRIMITIVE_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pa_pkg.sv @@
// ---------------------------------------------------------------------------
// pa_pkg
// Types and codes of the primitive assembler.
// ---------------------------------------------------------------------------
package pa_pkg;

   // Width of a vertex handle on the ports, and the part of it that is kept.
   localparam int VID_W    = 16;
   localparam int ID_WIDTH = 16;
   localparam int SLOT_W   = (ID_WIDTH < VID_W) ? ID_WIDTH : VID_W;

   localparam logic [1:0] REQ_BEGIN  = 2'd0;
   localparam logic [1:0] REQ_VERTEX = 2'd1;
   localparam logic [1:0] REQ_END    = 2'd2;

   localparam logic [3:0] MODE_POINTS = 4'd0;
   localparam logic [3:0] MODE_LINES  = 4'd1;
   localparam logic [3:0] MODE_LOOP   = 4'd2;
   localparam logic [3:0] MODE_LSTRIP = 4'd3;
   localparam logic [3:0] MODE_TRIS   = 4'd4;
   localparam logic [3:0] MODE_TSTRIP = 4'd5;
   localparam logic [3:0] MODE_FAN    = 4'd6;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_POINT = 2'd1;
   localparam logic [1:0] KIND_LINE  = 2'd2;
   localparam logic [1:0] KIND_TRI   = 2'd3;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_OP   = 2'd1;
   localparam logic [1:0] ERR_ENUM = 2'd2;

   typedef logic [SLOT_W-1:0] slot_type;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [3:0]       prim_mode;
      logic [VID_W-1:0] vertex_id;
   } pa_req_type;

   typedef struct packed {
      logic [1:0]       draw_kind;
      logic [VID_W-1:0] first_vertex;
      logic [VID_W-1:0] second_vertex;
      logic [VID_W-1:0] third_vertex;
      logic [1:0]       error_code;
   } pa_rsp_type;

   // Zero-extend a kept handle back to port width.
   function automatic logic [VID_W-1:0] to_vid(input slot_type s);
      logic [VID_W-1:0] r;
      r = '0;
      r[SLOT_W-1:0] = s;
      return r;
   endfunction

endpackage

@@ rtl/primitive_assembler.sv @@
// ---------------------------------------------------------------------------
// primitive_assembler
// Begin / vertex / end primitive assembly into point, line and triangle items.
// ---------------------------------------------------------------------------
// Takes one request item per cycle while req_ready is high and returns
// exactly one result item for each, in order, in the cycle after acceptance.
// The assembly state (open flag, mode, slot fill, vertex count and three
// handle slots) is updated at the edge that accepts the request; the result
// sits in a single output register that is refilled in the same cycle it is
// taken, so throughput is one item per clock while rsp_ready stays high.
// req_ready drops only while a result is held and not being taken.
module primitive_assembler
   import pa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  pa_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output pa_rsp_type rsp_data
);

`include "primitive_assembler_defines.svh"

   logic       open_ff, open_in;
   logic [3:0] mode_ff, mode_in;
   logic [1:0] fill_ff, fill_in;
   logic [1:0] capped_ff, capped_in;
   logic       parity_ff, parity_in;
   slot_type   slot_ff [3];
   slot_type   slot_in [3];
   logic       rsp_valid_ff;
   pa_rsp_type rsp_data_ff, rsp_in;

   logic       req_fire;
   slot_type   id_kept;
   slot_type   wslot [3];
   logic [1:0] n;
   logic [1:0] n_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign id_kept   = req_data.vertex_id[SLOT_W-1:0];

   // Slot to fill, and the slots with the new handle written in.
   assign n      = (fill_ff == 2'd3) ? 2'd0 : fill_ff;
   assign n_next = n + 2'd1;

   always_comb begin
      wslot = slot_ff;
      case (n)
         2'd1:    wslot[1] = id_kept;
         2'd2:    wslot[2] = id_kept;
         default: wslot[0] = id_kept;
      endcase
   end

   always_comb begin
      open_in   = open_ff;
      mode_in   = mode_ff;
      fill_in   = fill_ff;
      capped_in = capped_ff;
      parity_in = parity_ff;
      slot_in   = slot_ff;
      rsp_in    = '0;

      unique case (req_data.req_type)
         REQ_BEGIN: begin
            if (open_ff) begin
               rsp_in.error_code = ERR_OP;
            end else begin
               open_in   = 1'b1;
               mode_in   = req_data.prim_mode;
               fill_in   = 2'd0;
               capped_in = 2'd0;
               parity_in = 1'b0;
            end
         end
         REQ_VERTEX: begin
            if (!open_ff) begin
               rsp_in.error_code = ERR_OP;
            end else begin
               capped_in = (capped_ff == 2'd3) ? 2'd3 : capped_ff + 2'd1;
               parity_in = !parity_ff;
               slot_in   = wslot;
               fill_in   = n_next;
               unique case (mode_ff) inside
                  MODE_POINTS: begin
                     rsp_in.draw_kind    = KIND_POINT;
                     rsp_in.first_vertex = to_vid(wslot[0]);
                     fill_in             = 2'd0;
                  end
                  MODE_LINES: begin
                     if (n_next == 2'd2) begin
                        rsp_in.draw_kind     = KIND_LINE;
                        rsp_in.first_vertex  = to_vid(wslot[0]);
                        rsp_in.second_vertex = to_vid(wslot[1]);
                        fill_in              = 2'd0;
                     end
                  end
                  MODE_LOOP, MODE_LSTRIP: begin
                     // slot 2 keeps the loop's first vertex for the close
                     if (n_next == 2'd1) begin
                        slot_in[2] = wslot[0];
                     end else if (n_next == 2'd2) begin
                        rsp_in.draw_kind     = KIND_LINE;
                        rsp_in.first_vertex  = to_vid(wslot[0]);
                        rsp_in.second_vertex = to_vid(wslot[1]);
                        slot_in[0]           = wslot[1];
                        fill_in              = 2'd1;
                     end
                  end
                  MODE_TRIS: begin
                     if (n_next == 2'd3) begin
                        rsp_in.draw_kind     = KIND_TRI;
                        rsp_in.first_vertex  = to_vid(wslot[0]);
                        rsp_in.second_vertex = to_vid(wslot[1]);
                        rsp_in.third_vertex  = to_vid(wslot[2]);
                        fill_in              = 2'd0;
                     end
                  end
                  MODE_TSTRIP: begin
                     if (capped_in == 2'd3) begin
                        if (n_next == 2'd3) begin
                           fill_in = 2'd0;
                        end
                        rsp_in.draw_kind     = KIND_TRI;
                        rsp_in.second_vertex = to_vid(wslot[1]);
                        // even count reverses the winding
                        if (!parity_in) begin
                           rsp_in.first_vertex = to_vid(wslot[2]);
                           rsp_in.third_vertex = to_vid(wslot[0]);
                        end else begin
                           rsp_in.first_vertex = to_vid(wslot[0]);
                           rsp_in.third_vertex = to_vid(wslot[2]);
                        end
                     end
                  end
                  MODE_FAN: begin
                     if (n_next == 2'd3) begin
                        rsp_in.draw_kind     = KIND_TRI;
                        rsp_in.first_vertex  = to_vid(wslot[0]);
                        rsp_in.second_vertex = to_vid(wslot[1]);
                        rsp_in.third_vertex  = to_vid(wslot[2]);
                        slot_in[1]           = wslot[2];
                        fill_in              = 2'd2;
                     end
                  end
                  default: begin
                     rsp_in.error_code = ERR_ENUM;
                     fill_in           = 2'd0;
                  end
               endcase
            end
         end
         REQ_END: begin
            if (!open_ff) begin
               rsp_in.error_code = ERR_OP;
            end else begin
               if (mode_ff == MODE_LOOP && capped_ff == 2'd3) begin
                  rsp_in.draw_kind     = KIND_LINE;
                  rsp_in.first_vertex  = to_vid(slot_ff[0]);
                  rsp_in.second_vertex = to_vid(slot_ff[2]);
               end
               open_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         mode_ff   <= MODE_POINTS;
         fill_ff   <= 2'd0;
         capped_ff <= 2'd0;
         parity_ff <= 1'b0;
      end else if (req_fire) begin
         open_ff   <= open_in;
         mode_ff   <= mode_in;
         fill_ff   <= fill_in;
         capped_ff <= capped_in;
         parity_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         slot_ff     <= slot_in;
         rsp_data_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   `PA_ASSERT_NOW(a_fill_range, clock, reset, 1'b1, fill_ff != 2'd3, "fill count reached 3")

   `PA_ASSERT_NOW(a_parity_tracks, clock, reset, capped_ff != 2'd3, parity_ff == capped_ff[0], "parity out of step with count")

   `PA_ASSERT_NOW(a_draw_no_err, clock, reset, rsp_valid_ff && rsp_data_ff.draw_kind != KIND_NONE, rsp_data_ff.error_code == ERR_NONE, "draw item carries an error")

   `PA_ASSERT_NEXT(a_stray_vertex, clock, reset, req_fire && req_data.req_type == REQ_VERTEX && !open_ff, rsp_valid_ff && rsp_data_ff.error_code == ERR_OP && !open_ff, "vertex outside begin not flagged")

endmodule

@@ tb/tb_primitive_assembler.sv @@
// ---------------------------------------------------------------------------
// tb_primitive_assembler
// Self-checking bench for the begin / vertex / end primitive assembler.
// ---------------------------------------------------------------------------
// Begin, vertex and end items go out through a bursty valid/ready driver.
// The monitor runs a local assembly model on every accepted request and
// compares each accepted result with the oldest prediction, field by field.
// Stimulus is a short directed set of error and mode corner cases, followed by
// random primitives of every mode mixed with stray requests.
// ---------------------------------------------------------------------------
module tb_primitive_assembler
   import pa_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] REQ_UNKNOWN    = 2'd3;
   localparam logic [3:0] MODE_BAD       = 4'd15;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam int         STIM_TARGET    = 1300;

   logic       clock;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   pa_req_type req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   pa_rsp_type rsp_data;

   primitive_assembler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   pa_req_type pending_reqs[$];
   bit         pause_flags[$];
   pa_rsp_type expected_rsps[$];
   bit         hold_next  = 1'b0;
   int         stim_count = 0;
   int         fail_count = 0;
   logic       all_done   = 1'b1;

   // local copy of the assembly state
   logic       prim_open;
   logic [3:0] prim_mode_q;
   logic [1:0] fill_slot;
   logic [1:0] vert_count;
   logic       vert_odd;
   slot_type   held_ids [0:2];

   function automatic pa_rsp_type assemble_step(input pa_req_type r);
      pa_rsp_type o;
      logic [1:0] n;
      o = '0;
      case (r.req_type)
         REQ_BEGIN: begin
            if (prim_open) begin
               o.error_code = ERR_OP;
            end else begin
               prim_mode_q = r.prim_mode;
               prim_open   = 1'b1;
               fill_slot   = 2'd0;
               vert_count  = 2'd0;
               vert_odd    = 1'b0;
            end
         end
         REQ_VERTEX: begin
            if (!prim_open) begin
               o.error_code = ERR_OP;
            end else begin
               n = (fill_slot == 2'd3) ? 2'd0 : fill_slot;
               if (vert_count != 2'd3) vert_count = vert_count + 2'd1;
               vert_odd = ~vert_odd;
               held_ids[n] = r.vertex_id[SLOT_W-1:0];
               n = n + 2'd1;
               case (prim_mode_q)
                  MODE_POINTS: begin
                     o.draw_kind    = KIND_POINT;
                     o.first_vertex = held_ids[0];
                     n = 2'd0;
                  end
                  MODE_LINES: begin
                     if (n == 2'd2) begin
                        o.draw_kind     = KIND_LINE;
                        o.first_vertex  = held_ids[0];
                        o.second_vertex = held_ids[1];
                        n = 2'd0;
                     end
                  end
                  MODE_LOOP, MODE_LSTRIP: begin
                     // slot 2 keeps the opening vertex for the loop's closing line
                     if (n == 2'd1) begin
                        held_ids[2] = held_ids[0];
                     end else if (n == 2'd2) begin
                        o.draw_kind     = KIND_LINE;
                        o.first_vertex  = held_ids[0];
                        o.second_vertex = held_ids[1];
                        held_ids[0] = held_ids[1];
                        n = 2'd1;
                     end
                  end
                  MODE_TRIS: begin
                     if (n == 2'd3) begin
                        o.draw_kind     = KIND_TRI;
                        o.first_vertex  = held_ids[0];
                        o.second_vertex = held_ids[1];
                        o.third_vertex  = held_ids[2];
                        n = 2'd0;
                     end
                  end
                  MODE_TSTRIP: begin
                     if (vert_count == 2'd3) begin
                        if (n == 2'd3) n = 2'd0;
                        o.draw_kind     = KIND_TRI;
                        o.second_vertex = held_ids[1];
                        // winding flips with the vertex count parity
                        if (vert_odd) begin
                           o.first_vertex = held_ids[0];
                           o.third_vertex = held_ids[2];
                        end else begin
                           o.first_vertex = held_ids[2];
                           o.third_vertex = held_ids[0];
                        end
                     end
                  end
                  MODE_FAN: begin
                     if (n == 2'd3) begin
                        o.draw_kind     = KIND_TRI;
                        o.first_vertex  = held_ids[0];
                        o.second_vertex = held_ids[1];
                        o.third_vertex  = held_ids[2];
                        held_ids[1] = held_ids[2];
                        n = 2'd2;
                     end
                  end
                  default: begin
                     o.error_code = ERR_ENUM;
                     n = 2'd0;
                  end
               endcase
               fill_slot = n;
            end
         end
         REQ_END: begin
            if (!prim_open) begin
               o.error_code = ERR_OP;
            end else begin
               if (prim_mode_q == MODE_LOOP && vert_count == 2'd3) begin
                  o.draw_kind     = KIND_LINE;
                  o.first_vertex  = held_ids[0];
                  o.second_vertex = held_ids[2];
               end
               prim_open = 1'b0;
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic check_field(input string name, input logic [VID_W-1:0] exp_v,
                              input logic [VID_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   task automatic add_req(input logic [1:0] kind, input logic [3:0] mode,
                          input logic [VID_W-1:0] id);
      pa_req_type r;
      r.req_type  = kind;
      r.prim_mode = mode;
      r.vertex_id = id;
      pending_reqs.push_back(r);
      pause_flags.push_back(hold_next);
      hold_next = 1'b0;
      if (kind != REQ_UNKNOWN) stim_count++;
   endtask

   task automatic add_prim(input logic [3:0] mode, input int verts);
      add_req(REQ_BEGIN, mode, VID_W'($urandom));
      repeat (verts) add_req(REQ_VERTEX, 4'($urandom), VID_W'($urandom));
      add_req(REQ_END, 4'($urandom), VID_W'($urandom));
   endtask

   // driver: bursts of items separated by random gaps
   int gap_left   = 0;
   int burst_left = 0;

   always @(posedge clock) begin : driver
      logic       take;
      pa_req_type nxt;
      take = 1'b0;
      nxt  = '0;
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         gap_left   = 0;
         burst_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_reqs.size() != 0) begin
            // a paused item waits until every result so far has been checked
            if (!pause_flags[0] || (all_done && !req_valid)) take = 1'b1;
         end
         if (take) begin
            nxt = pending_reqs.pop_front();
            void'(pause_flags.pop_front());
            if (burst_left != 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
            req_data <= nxt;
         end
         req_valid <= take;
      end
   end

   // receiver: ready follows a random bit pattern, sometimes solid high
   logic [31:0] stall_bits = 32'hFFFF_FFFF;
   int          stall_left = 0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0) begin
            stall_bits = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : ($urandom | 32'd1);
            stall_left = 32;
         end
         rsp_ready <= stall_bits[0];
         stall_bits = {stall_bits[0], stall_bits[31:1]};
         stall_left--;
      end
   end

   always @(posedge clock) begin : monitor
      pa_rsp_type want;
      if (reset) begin
         prim_open   = 1'b0;
         prim_mode_q = MODE_POINTS;
         fill_slot   = 2'd0;
         vert_count  = 2'd0;
         vert_odd    = 1'b0;
         held_ids    = '{default: '0};
         expected_rsps.delete();
         all_done <= 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result item with nothing expected: %p", rsp_data);
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("draw_kind", VID_W'(want.draw_kind), VID_W'(rsp_data.draw_kind));
               check_field("first_vertex", want.first_vertex, rsp_data.first_vertex);
               check_field("second_vertex", want.second_vertex, rsp_data.second_vertex);
               check_field("third_vertex", want.third_vertex, rsp_data.third_vertex);
               check_field("error_code", VID_W'(want.error_code),
                           VID_W'(rsp_data.error_code));
            end
         end
         if (req_valid && req_ready) expected_rsps.push_back(assemble_step(req_data));
         all_done <= (expected_rsps.size() == 0);
      end
   end

   int idle_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int         pick;
      logic [3:0] mode;
      int         verts;

      // errors outside a primitive, and the unknown request type
      add_req(REQ_END, MODE_BAD, 16'hFFFF);
      add_req(REQ_VERTEX, MODE_BAD, 16'hFFFF);
      add_req(REQ_UNKNOWN, MODE_BAD, 16'hFFFF);
      // points, with a begin while already open
      add_req(REQ_BEGIN, MODE_POINTS, 16'h0000);
      add_req(REQ_BEGIN, MODE_FAN, 16'h0000);
      add_req(REQ_VERTEX, MODE_POINTS, 16'hFFFF);
      add_req(REQ_VERTEX, MODE_POINTS, 16'h0000);
      add_req(REQ_END, MODE_POINTS, 16'h0000);
      // line loop too short to close, then one that closes
      add_prim(MODE_LOOP, 2);
      hold_next = 1'b1;
      add_prim(MODE_LOOP, 3);
      // strip winding both ways
      add_prim(MODE_TSTRIP, 4);
      // unknown mode: every vertex flagged
      add_prim(MODE_BAD, 1);

      while (stim_count < STIM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            if ($urandom_range(0, 9) == 0) mode = 4'($urandom_range(7, 15));
            else mode = 4'($urandom_range(0, 6));
            if ($urandom_range(0, 7) == 0) verts = $urandom_range(10, 20);
            else verts = $urandom_range(0, 9);
            if (pick < 2) hold_next = 1'b1;
            add_prim(mode, verts);
         end else begin
            // stray request: breaks or nests the surrounding sequence
            add_req(2'($urandom_range(0, 3)), 4'($urandom), VID_W'($urandom));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      @(posedge clock);
      while (!all_done) @(posedge clock);
      repeat (8) @(posedge clock);

      if (expected_rsps.size() != 0) begin
         $error("%0d result items never arrived", expected_rsps.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
